[rtl/hsvrgb_pkg.sv]
// Package for the HSV to RGB level scaler: word types, constants and the hue table.
package hsvrgb_pkg;

   localparam int ScaleMax   = 254;
   localparam int FullCircle = 360;
   localparam int SectorDeg  = 60;
   localparam int ValueMax   = 255;

   // x/254 and x/60 by reciprocal, both slightly low; one correction step fixes them
   localparam int Recip254   = 258;
   localparam int Recip60    = 1092;
   localparam int RecipShift = 16;

   typedef struct packed {
      logic       lamp_on;
      logic [7:0] level;
      logic [7:0] hue;
      logic [7:0] saturation;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_word_type;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic [5:0] rem;
   } hue_entry_type;

   typedef hue_entry_type [255:0] hue_tab_type;

   // control and shared fields carried down the pipe with each word
   typedef struct packed {
      logic       valid;
      logic       lamp_on;
      logic [7:0] value;
      logic [7:0] sat;
      sector_type sector;
   } ctl_type;

   // raw hue code -> sector and remainder; codes above full scale clamp, 360 deg wraps to 0
   function automatic hue_tab_type build_hue_tab();
      hue_tab_type tab;
      int          hh;
      int          deg;
      for (int i = 0; i < 256; i++) begin
         hh  = (i > ScaleMax) ? ScaleMax : i;
         deg = hh * FullCircle / ScaleMax;
         if (deg >= FullCircle) begin
            deg = 0;
         end
         tab[i].sector = sector_type'(deg / SectorDeg);
         tab[i].rem    = 6'(deg % SectorDeg);
      end
      return tab;
   endfunction

   localparam hue_tab_type HueTab = build_hue_tab();

endpackage

[rtl/hsvrgb_div254.sv]
// Two-stage divide by 254 of a 16-bit product: reciprocal estimate, then one correction.
module hsvrgb_div254
   import hsvrgb_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] dividend,
   output logic [7:0]  quotient
);

   logic [24:0] est_prod;
   logic [8:0]  est_in;
   logic [8:0]  est_ff;
   logic [15:0] x_ff;
   logic [16:0] back;
   logic [16:0] rest;
   logic [8:0]  quo_in;
   logic [7:0]  quo_ff;

   always_comb begin
      est_prod = 25'(dividend) * 25'(Recip254);
      est_in   = est_prod[RecipShift +: 9];
   end

   always_ff @(posedge clock) begin
      est_ff <= est_in;
      x_ff   <= dividend;
   end

   // estimate is exact or one low
   always_comb begin
      back = 17'(est_ff) * 17'(ScaleMax);
      rest = 17'(x_ff) - back;
      if (rest >= 17'(ScaleMax)) begin
         quo_in = est_ff + 9'd1;
      end else begin
         quo_in = est_ff;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in[7:0];
   end

   assign quotient = quo_ff;

endmodule

[rtl/hsv_to_rgb_level_scaler.sv]
// Top level: pipelined HSV lamp setting to RGB color converter.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------------------
//  request | start, busy, req_word       | word taken at an edge with start & !busy
//  result  | rsp_valid, rsp_word         | one-cycle strobe, no back-pressure
//
// One word in per cycle; busy never rises. Each result passes the input reg, 7 work
// stages and the output reg on its way to the ports.
// Cycle budget is set by the chain of constant divides: /60 of sat*rem and /254
// of value products each take a reciprocal stage plus a correction stage.
// Reset (synchronous) clears the valid flags and the ctl words; other data regs run free.
// With no stall on either side the pipe simply advances every clock.
module hsv_to_rgb_level_scaler
   import hsvrgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   // ---------------- stage 0: capture request word
   req_word_type in_ff;
   logic         in_vld_ff;
   logic         in_vld_in;

   assign busy      = 1'b0;
   assign in_vld_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= req_word;
   end

   // ---------------- stage 1: clamp inputs, value scale, hue table lookup
   ctl_type       ctl1_in, ctl1_ff;
   logic [5:0]    rem1_in, rem1_ff;
   logic [7:0]    lvl1;
   hue_entry_type hent1;

   always_comb begin
      lvl1  = (in_ff.level > 8'(ScaleMax)) ? 8'(ScaleMax) : in_ff.level;
      hent1 = HueTab[in_ff.hue];
      ctl1_in.valid   = in_vld_ff;
      ctl1_in.lamp_on = in_ff.lamp_on;
      // level*255/254 is level, except full scale which lands on 255
      ctl1_in.value   = (lvl1 == 8'(ScaleMax)) ? 8'(ValueMax) : lvl1;
      ctl1_in.sat     = (in_ff.saturation > 8'(ScaleMax)) ? 8'(ScaleMax) : in_ff.saturation;
      ctl1_in.sector  = hent1.sector;
      rem1_in         = hent1.rem;
   end

   // ---------------- stage 2: sat*rem and sat*(60-rem)
   ctl_type     ctl2_in, ctl2_ff;
   logic [13:0] mq2_in, mq2_ff;
   logic [13:0] mt2_in, mt2_ff;

   always_comb begin
      ctl2_in = ctl1_ff;
      mq2_in  = 14'(ctl1_ff.sat) * 14'(rem1_ff);
      mt2_in  = 14'(ctl1_ff.sat) * 14'(6'(SectorDeg) - rem1_ff);
   end

   // ---------------- stage 3: /60 reciprocal estimates
   ctl_type     ctl3_in, ctl3_ff;
   logic [7:0]  eq3_in, eq3_ff;
   logic [7:0]  et3_in, et3_ff;
   logic [13:0] xq3_ff, xt3_ff;
   logic [23:0] pq3, pt3;

   always_comb begin
      ctl3_in = ctl2_ff;
      pq3     = 24'(mq2_ff) * 24'(Recip60);
      pt3     = 24'(mt2_ff) * 24'(Recip60);
      eq3_in  = pq3[RecipShift +: 8];
      et3_in  = pt3[RecipShift +: 8];
   end

   // ---------------- stage 4: /60 correction, estimate exact or one low
   ctl_type     ctl4_in, ctl4_ff;
   logic [7:0]  kq4_in, kq4_ff;
   logic [7:0]  kt4_in, kt4_ff;
   logic [13:0] rq4, rt4;

   always_comb begin
      ctl4_in = ctl3_ff;
      rq4     = xq3_ff - 14'(eq3_ff) * 14'(SectorDeg);
      rt4     = xt3_ff - 14'(et3_ff) * 14'(SectorDeg);
      kq4_in  = (rq4 >= 14'(SectorDeg)) ? eq3_ff + 8'd1 : eq3_ff;
      kt4_in  = (rt4 >= 14'(SectorDeg)) ? et3_ff + 8'd1 : et3_ff;
   end

   // ---------------- stage 5: value * (254 - sat) for p, value * (254 - k) for q, t
   ctl_type     ctl5_in, ctl5_ff;
   logic [15:0] pp5_in, pp5_ff;
   logic [15:0] pq5_in, pq5_ff;
   logic [15:0] pt5_in, pt5_ff;

   always_comb begin
      ctl5_in = ctl4_ff;
      pp5_in  = 16'(ctl4_ff.value) * 16'(8'(ScaleMax) - ctl4_ff.sat);
      pq5_in  = 16'(ctl4_ff.value) * 16'(8'(ScaleMax) - kq4_ff);
      pt5_in  = 16'(ctl4_ff.value) * 16'(8'(ScaleMax) - kt4_ff);
   end

   // ---------------- stages 6-7: /254 in the divider units
   ctl_type    ctl6_in, ctl6_ff;
   ctl_type    ctl7_in, ctl7_ff;
   logic [7:0] p7, q7, t7;

   assign ctl6_in = ctl5_ff;
   assign ctl7_in = ctl6_ff;

   hsvrgb_div254 u_div_p (.clock(clock), .dividend(pp5_ff), .quotient(p7));
   hsvrgb_div254 u_div_q (.clock(clock), .dividend(pq5_ff), .quotient(q7));
   hsvrgb_div254 u_div_t (.clock(clock), .dividend(pt5_ff), .quotient(t7));

   // ---------------- stage 8: sector mapping into the result register
   logic         rsp_valid_in, rsp_valid_ff;
   rsp_word_type rsp_word_in, rsp_word_ff;
   rsp_word_type hue_rgb;
   logic [7:0]   v7;

   always_comb begin
      v7 = ctl7_ff.value;
      unique case (ctl7_ff.sector)
         SEC_RED_YEL: hue_rgb = '{red: v7, green: t7, blue: p7};
         SEC_YEL_GRN: hue_rgb = '{red: q7, green: v7, blue: p7};
         SEC_GRN_CYN: hue_rgb = '{red: p7, green: v7, blue: t7};
         SEC_CYN_BLU: hue_rgb = '{red: p7, green: q7, blue: v7};
         SEC_BLU_MAG: hue_rgb = '{red: t7, green: p7, blue: v7};
         default:     hue_rgb = '{red: v7, green: p7, blue: q7};
      endcase
   end

   always_comb begin
      rsp_valid_in = ctl7_ff.valid;
      priority if (!ctl7_ff.lamp_on) begin
         rsp_word_in = '0;                         // lamp off: black
      end else if (ctl7_ff.sat == 8'd0) begin
         rsp_word_in = '{red: v7, green: v7, blue: v7}; // grey
      end else begin
         rsp_word_in = hue_rgb;
      end
   end

   // ---------------- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff      <= '0;
         ctl2_ff      <= '0;
         ctl3_ff      <= '0;
         ctl4_ff      <= '0;
         ctl5_ff      <= '0;
         ctl6_ff      <= '0;
         ctl7_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl1_ff      <= ctl1_in;
         ctl2_ff      <= ctl2_in;
         ctl3_ff      <= ctl3_in;
         ctl4_ff      <= ctl4_in;
         ctl5_ff      <= ctl5_in;
         ctl6_ff      <= ctl6_in;
         ctl7_ff      <= ctl7_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem1_ff     <= rem1_in;
      mq2_ff      <= mq2_in;
      mt2_ff      <= mt2_in;
      eq3_ff      <= eq3_in;
      et3_ff      <= et3_in;
      xq3_ff      <= mq2_ff;
      xt3_ff      <= mt2_ff;
      kq4_ff      <= kq4_in;
      kt4_ff      <= kt4_in;
      pp5_ff      <= pp5_in;
      pq5_ff      <= pq5_in;
      pt5_ff      <= pt5_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
